// ===== rtl/nx_length_statistic_table_top_defines.svh =====
// Assertion macros for the length-statistic table checker.
`ifndef NX_LENGTH_STATISTIC_TABLE_TOP_DEFINES_SVH
`define NX_LENGTH_STATISTIC_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define NX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nx_lst_pkg.sv =====
// Types and codes shared by the length-statistic table modules.
package nx_lst_pkg;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_ADD_SCORE = 2'd1,
        OP_SORT      = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_NOT_REACHED = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] entry_id;
        logic [31:0]        entry_size;
        logic signed [31:0] score_delta;
        logic [15:0]        percent_q8;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_id;
        logic [31:0]        found_size;
        logic signed [31:0] found_score;
        logic [10:0]        entries_held;
        logic [31:0]        largest_size;
        logic [30:0]        largest_score;
        logic [47:0]        size_total;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] id;
        logic [31:0]        size;
        logic signed [31:0] score;
    } t_entry;

endpackage

// ===== rtl/nx_lst_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
module nx_lst_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  nx_lst_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output nx_lst_pkg::t_entry o_rd_data
);
    import nx_lst_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/nx_length_statistic_table_top.sv =====
// Top level of the length-statistic table (N50-style Nx query over a sortable table).
// One request at a time; every request gives one response, and the input stays stalled from
// acceptance until the response is registered. An add, a sort of fewer than two entries and
// every request that ends early on an empty table or a zero total go straight from the execute
// state to the response. Add score reads and checks each entry from entry 0 up to the match,
// then writes it back. Query first forms the threshold product, then reads, accumulates and
// compares each entry up to the hit. Sort is an in-place insertion sort: each key is read, then
// compared with the entries before it, shifting up each one it goes before, until its place.
// A stalled response holds the block until it is taken. The walks are paced by the one read
// port of the entry memory, whose read data is registered. Config must be written only while
// no request is in flight; the block itself does not enforce this.
module nx_length_statistic_table_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  nx_lst_pkg::t_req i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output nx_lst_pkg::t_rsp o_out_rsp
);
    import nx_lst_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC,
        S_FIND_RD, S_FIND_CHK, S_FIND_WR,
        S_SORT_KEY_RD, S_SORT_KEY_LD, S_SORT_RD, S_SORT_CMP, S_SORT_PUT,
        S_Q_MUL, S_Q_RD, S_Q_ACC, S_Q_CMP,
        S_DONE
    } t_state;

    t_state             r_state;
    t_req               r_req;
    t_status            r_status;
    t_entry             r_found;
    t_entry             r_key;
    logic               r_sort_by_score;
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_j;
    logic [47:0]        r_total;
    logic [31:0]        r_peak_size;
    logic signed [31:0] r_peak_score;
    logic [47:0]        r_cum;
    logic [63:0]        r_rhs;
    logic               r_out_valid;
    t_rsp               r_out_rsp;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    t_entry             rd_data;

    logic signed [31:0] sat_score;
    logic               key_before;
    logic [63:0]        cum_scaled;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      j_next;
    logic [CW+10:0]     fill_ext;
    logic               out_free;

    always_comb begin
        logic signed [32:0] sum;
        sum = {rd_data.score[31], rd_data.score} + {r_req.score_delta[31], r_req.score_delta};
        if (sum[32] != sum[31]) begin
            sat_score = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_score = sum[31:0];
        end
    end

    always_comb begin
        if (r_sort_by_score && (r_key.score != rd_data.score)) begin
            key_before = r_key.score > rd_data.score;
        end else begin
            key_before = r_key.size > rd_data.size;
        end
    end

    // 25600 = 2^14 + 2^13 + 2^10
    assign cum_scaled = ({16'd0, r_cum} << 14) + ({16'd0, r_cum} << 13)
                      + ({16'd0, r_cum} << 10);
    assign idx_next   = r_idx + ONE_C;
    assign j_next     = r_j - ONE_C;
    assign fill_ext   = {11'd0, r_fill};
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_key;
        rd_en   = 1'b0;
        rd_addr = r_idx[AW-1:0];
        case (r_state)
            S_EXEC: begin
                if (r_req.operation == OP_ADD && r_fill != DEPTH_C) begin
                    wr_en   = 1'b1;
                    wr_addr = r_fill[AW-1:0];
                    wr_data = '{id: r_req.entry_id, size: r_req.entry_size, score: '0};
                end
            end
            S_FIND_RD, S_SORT_KEY_RD, S_Q_RD: begin
                rd_en = 1'b1;
            end
            S_FIND_WR: begin
                wr_en   = 1'b1;
                wr_data = r_key;
            end
            S_SORT_RD: begin
                rd_en   = 1'b1;
                rd_addr = j_next[AW-1:0];
            end
            S_SORT_CMP: begin
                if (key_before) begin
                    wr_en   = 1'b1;
                    wr_addr = r_j[AW-1:0];
                    wr_data = rd_data;
                end
            end
            S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_key;
            end
            default: begin
            end
        endcase
    end

    nx_lst_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_sort_by_score <= 1'b0;
            r_fill          <= '0;
            r_total         <= '0;
            r_peak_size     <= '0;
            r_peak_score    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sort_by_score <= i_cfg_wdata;
            end
            // in S_DONE the valid flag is handled by the state itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= i_in_req;
                        r_status <= ST_OK;
                        r_found  <= '0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_idx <= (t_op'(r_req.operation) == OP_SORT) ? ONE_C : '0;
                    r_cum <= '0;
                    case (t_op'(r_req.operation))
                        OP_ADD: begin
                            if (r_fill == DEPTH_C) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_fill  <= r_fill + ONE_C;
                                r_total <= r_total + {16'd0, r_req.entry_size};
                                if (r_req.entry_size > r_peak_size) begin
                                    r_peak_size <= r_req.entry_size;
                                end
                            end
                            r_state <= S_DONE;
                        end
                        OP_ADD_SCORE: begin
                            if (r_fill == '0) begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_FIND_RD;
                            end
                        end
                        OP_SORT: begin
                            r_state <= (r_fill > ONE_C) ? S_SORT_KEY_RD : S_DONE;
                        end
                        default: begin
                            if (r_fill == '0 || r_total == '0) begin
                                r_status <= ST_NOT_REACHED;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_Q_MUL;
                            end
                        end
                    endcase
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_CHK;
                end
                S_FIND_CHK: begin
                    if (rd_data.id == r_req.entry_id) begin
                        r_key   <= '{id: rd_data.id, size: rd_data.size, score: sat_score};
                        r_state <= S_FIND_WR;
                    end else if (idx_next == r_fill) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= idx_next;
                        r_state <= S_FIND_RD;
                    end
                end
                S_FIND_WR: begin
                    if (r_key.score > r_peak_score) begin
                        r_peak_score <= r_key.score;
                    end
                    r_state <= S_DONE;
                end
                S_SORT_KEY_RD: begin
                    r_j     <= r_idx;
                    r_state <= S_SORT_KEY_LD;
                end
                S_SORT_KEY_LD: begin
                    r_key   <= rd_data;
                    r_state <= S_SORT_RD;
                end
                S_SORT_RD: begin
                    r_state <= S_SORT_CMP;
                end
                S_SORT_CMP: begin
                    if (key_before) begin
                        r_j     <= j_next;
                        r_state <= (j_next == '0) ? S_SORT_PUT : S_SORT_RD;
                    end else begin
                        r_state <= S_SORT_PUT;
                    end
                end
                S_SORT_PUT: begin
                    r_idx   <= idx_next;
                    r_state <= (idx_next == r_fill) ? S_DONE : S_SORT_KEY_RD;
                end
                S_Q_MUL: begin
                    r_rhs   <= {48'd0, r_req.percent_q8} * {16'd0, r_total};
                    r_state <= S_Q_RD;
                end
                S_Q_RD: begin
                    r_state <= S_Q_ACC;
                end
                S_Q_ACC: begin
                    r_cum   <= r_cum + {16'd0, rd_data.size};
                    r_key   <= rd_data;
                    r_state <= S_Q_CMP;
                end
                S_Q_CMP: begin
                    if (cum_scaled >= r_rhs) begin
                        r_found <= r_key;
                        r_state <= S_DONE;
                    end else if (idx_next == r_fill) begin
                        r_status <= ST_NOT_REACHED;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= idx_next;
                        r_state <= S_Q_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid               <= 1'b1;
                        r_out_rsp.status          <= r_status;
                        r_out_rsp.found_id        <= r_found.id;
                        r_out_rsp.found_size      <= r_found.size;
                        r_out_rsp.found_score     <= r_found.score;
                        r_out_rsp.entries_held    <= fill_ext[10:0];
                        r_out_rsp.largest_size    <= r_peak_size;
                        r_out_rsp.largest_score   <= r_peak_score[30:0];
                        r_out_rsp.size_total      <= r_total;
                        r_state                   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;
endmodule

// ===== rtl/nx_lst_checker.sv =====
// Port-level checker for the length-statistic table, bound to the top level.
`include "nx_length_statistic_table_top_defines.svh"

module nx_lst_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic             i_cfg_wdata,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input nx_lst_pkg::t_req i_in_req,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input nx_lst_pkg::t_rsp o_out_rsp
);
    import nx_lst_pkg::*;

    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

    logic in_wait;
    logic out_wait;
    logic full_rsp;
    logic miss_rsp;
    logic found_zero;
    logic cfg_quiet;
    assign in_wait    = i_in_valid && o_in_stall;
    assign out_wait   = o_out_valid && i_out_stall;
    assign full_rsp   = o_out_valid && (o_out_rsp.status == ST_FULL);
    assign miss_rsp   = o_out_valid && (o_out_rsp.status != ST_OK);
    assign found_zero = (o_out_rsp.found_id == 32'sd0) && (o_out_rsp.found_size == 32'd0)
                     && (o_out_rsp.found_score == 32'sd0);
    assign cfg_quiet  = !o_in_stall && !o_out_valid && !$isunknown(i_cfg_wdata);

    `NX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_rsp), "response changed")
    `NX_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_in_req), "request changed")
    `NX_ASSERT_IMPL(a_full_count, i_clk, i_rst_n, full_rsp, o_out_rsp.entries_held == DEPTH_W[10:0], "table full with room left")
    `NX_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, miss_rsp, found_zero, "found fields nonzero on a miss")
    `NX_ASSERT_IMPL(a_cfg_idle, i_clk, i_rst_n, i_cfg_we, cfg_quiet, "config written while busy")
endmodule

bind nx_length_statistic_table_top nx_lst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_nx_lst_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for the length-statistic table: directed rows, then random requests.
module tb_top;
    import nx_lst_pkg::*;

    localparam int DEPTH = 1024;
    localparam int LIMIT = 4000000;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_req in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp out_rsp;

    nx_length_statistic_table_top #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_req(in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp(out_rsp)
    );

    // table mirror
    logic [31:0]        tab_id [DEPTH];
    logic [31:0]        tab_size [DEPTH];
    logic signed [31:0] tab_score [DEPTH];
    int                 held = 0;
    logic [47:0]        total = '0;
    logic [31:0]        peak_size = '0;
    logic signed [31:0] peak_score = '0;
    bit                 by_score = 1'b0;

    t_rsp pending_rsp[$];
    logic [31:0] id_pool[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    function automatic void table_sort();
        logic [31:0] mid, msz;
        logic signed [31:0] msc;
        int j;
        bit ahead;
        for (int i = 1; i < held; i++) begin
            mid = tab_id[i];
            msz = tab_size[i];
            msc = tab_score[i];
            j = i;
            while (j > 0) begin
                if (by_score && msc != tab_score[j-1])
                    ahead = msc > tab_score[j-1];
                else
                    ahead = msz > tab_size[j-1];
                if (!ahead)
                    break;
                tab_id[j] = tab_id[j-1];
                tab_size[j] = tab_size[j-1];
                tab_score[j] = tab_score[j-1];
                j--;
            end
            tab_id[j] = mid;
            tab_size[j] = msz;
            tab_score[j] = msc;
        end
    endfunction

    function automatic t_rsp table_predict(t_req r);
        t_rsp o;
        longint s;
        logic [63:0] cum, rhs;
        o = '0;
        case (r.operation)
            OP_ADD: begin
                if (held >= DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    tab_id[held] = r.entry_id;
                    tab_size[held] = r.entry_size;
                    tab_score[held] = '0;
                    held++;
                    total = total + r.entry_size;
                    if (r.entry_size > peak_size)
                        peak_size = r.entry_size;
                end
            end
            OP_ADD_SCORE: begin
                o.status = ST_NOT_FOUND;
                for (int i = 0; i < held; i++) begin
                    if (tab_id[i] == r.entry_id) begin
                        s = longint'(tab_score[i]) + longint'(r.score_delta);
                        if (s > 64'sd2147483647)
                            s = 64'sd2147483647;
                        if (s < -64'sd2147483648)
                            s = -64'sd2147483648;
                        tab_score[i] = s[31:0];
                        if (tab_score[i] > peak_score)
                            peak_score = tab_score[i];
                        o.status = ST_OK;
                        break;
                    end
                end
            end
            OP_SORT: table_sort();
            default: begin
                cum = '0;
                rhs = 64'(r.percent_q8) * 64'(total);
                o.status = ST_NOT_REACHED;
                if (total != 0) begin
                    for (int i = 0; i < held; i++) begin
                        cum = cum + tab_size[i];
                        if (cum * 64'd25600 >= rhs) begin
                            o.status = ST_OK;
                            o.found_id = tab_id[i];
                            o.found_size = tab_size[i];
                            o.found_score = tab_score[i];
                            break;
                        end
                    end
                end
            end
        endcase
        o.entries_held = held[10:0];
        o.largest_size = peak_size;
        o.largest_score = peak_score[30:0];
        o.size_total = total;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_rsp.size() == 0) begin
                $error("response with nothing expected");
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (out_rsp.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, out_rsp.status);
                    errors++;
                end
                if (out_rsp.found_id !== want.found_id) begin
                    $error("found_id exp %0h got %0h", want.found_id, out_rsp.found_id);
                    errors++;
                end
                if (out_rsp.found_size !== want.found_size) begin
                    $error("found_size exp %0h got %0h", want.found_size, out_rsp.found_size);
                    errors++;
                end
                if (out_rsp.found_score !== want.found_score) begin
                    $error("found_score exp %0h got %0h", want.found_score, out_rsp.found_score);
                    errors++;
                end
                if (out_rsp.entries_held !== want.entries_held) begin
                    $error("entries_held exp %0d got %0d", want.entries_held,
                           out_rsp.entries_held);
                    errors++;
                end
                if (out_rsp.largest_size !== want.largest_size) begin
                    $error("largest_size exp %0h got %0h", want.largest_size,
                           out_rsp.largest_size);
                    errors++;
                end
                if (out_rsp.largest_score !== want.largest_score) begin
                    $error("largest_score exp %0h got %0h", want.largest_score,
                           out_rsp.largest_score);
                    errors++;
                end
                if (out_rsp.size_total !== want.size_total) begin
                    $error("size_total exp %0h got %0h", want.size_total, out_rsp.size_total);
                    errors++;
                end
            end
        end
    end

    function automatic t_req mk_req(t_op op, logic [31:0] id, logic [31:0] sz,
                                    logic [31:0] dl, logic [15:0] pc);
        t_req r;
        r.operation = op;
        r.entry_id = id;
        r.entry_size = sz;
        r.score_delta = dl;
        r.percent_q8 = pc;
        return r;
    endfunction

    // keeps valid high across back-to-back requests
    task automatic send_req(t_req r, bit typed, t_rsp typed_rsp);
        int gap;
        t_rsp p;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        p = table_predict(r);
        if (typed)
            p = typed_rsp;
        pending_rsp = {pending_rsp, p};
    endtask

    task automatic write_cfg(bit v);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        by_score = v;
    endtask

    function automatic t_req rand_req();
        int pick;
        logic [31:0] id, sz, dl;
        logic [15:0] pc;
        pick = $urandom_range(99);
        id = $urandom;
        sz = $urandom;
        dl = $urandom;
        pc = 16'($urandom);
        case ($urandom_range(3))
            0: sz = $urandom_range(1000);
            1: sz = 32'd0;
            default: ;
        endcase
        case ($urandom_range(4))
            0: dl = 32'h7fffffff;
            1: dl = 32'h80000000;
            2: dl = $urandom_range(32'h40000) - 32'h20000;
            default: ;
        endcase
        if ($urandom_range(3) != 0)
            pc = 16'($urandom_range(25600));
        if (id_pool.size() > 0 && $urandom_range(9) < 8)
            id = id_pool[$urandom_range(id_pool.size() - 1)];
        if (pick < 30) begin
            if (id_pool.size() < 24)
                id_pool = {id_pool, id};
            return mk_req(OP_ADD, id, sz, dl, pc);
        end
        if (pick < 65)
            return mk_req(OP_ADD_SCORE, id, sz, dl, pc);
        if (pick < 70 && held < 120)
            return mk_req(OP_SORT, id, sz, dl, pc);
        return mk_req(OP_QUERY, id, sz, dl, pc);
    endfunction

    initial begin
        t_dir_row rows[$];
        t_dir_row row;
        t_rsp z;
        z = '0;

        row.typed = 1'b1;
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd25600);
        row.rsp = z;
        row.rsp.status = ST_NOT_REACHED;
        rows = {rows, row};
        row.req = mk_req(OP_ADD_SCORE, 32'd5, 32'd0, 32'd1, 16'd0);
        row.rsp = z;
        row.rsp.status = ST_NOT_FOUND;
        rows = {rows, row};
        row.req = mk_req(OP_ADD, 32'h80000000, 32'd0, 32'd0, 16'd0);
        row.rsp = z;
        row.rsp.entries_held = 11'd1;
        rows = {rows, row};
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd12800);
        row.rsp.status = ST_NOT_REACHED;
        rows = {rows, row};
        row.typed = 1'b0;
        row.req = mk_req(OP_ADD, 32'h7fffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
        rows = {rows, row};
        row.req = mk_req(OP_ADD, 32'd7, 32'd100, 32'd0, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_ADD, 32'd7, 32'd300, 32'd0, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_ADD_SCORE, 32'd7, 32'd0, 32'h7fffffff, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_ADD_SCORE, 32'd7, 32'd0, 32'h7fffffff, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_ADD_SCORE, 32'h80000000, 32'd0, 32'h80000000, 16'd0);
        rows = {rows, row};
        rows = {rows, row};
        row.req = mk_req(OP_ADD_SCORE, 32'h7fffffff, 32'd0, 32'h00010000, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd25600);
        rows = {rows, row};
        row.req = mk_req(OP_SORT, 32'd0, 32'd0, 32'd0, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd0);
        rows = {rows, row};
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd25600);
        rows = {rows, row};
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'hffff);
        rows = {rows, row};
        row.req = mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd12800);
        rows = {rows, row};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cfg(1'b0);

        send_idle = 12;
        recv_idle = 85;
        foreach (rows[k])
            send_req(rows[k].req, rows[k].typed, rows[k].rsp);

        write_cfg(1'b1);
        send_req(mk_req(OP_SORT, 32'd0, 32'd0, 32'd0, 16'd0), 1'b0, z);
        send_req(mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd6400), 1'b0, z);
        for (int n = 0; n < 150; n++)
            send_req(rand_req(), 1'b0, z);

        write_cfg(1'b0);
        send_idle = 85;
        recv_idle = 12;
        for (int n = 0; n < 150; n++)
            send_req(rand_req(), 1'b0, z);

        write_cfg(1'b1);
        send_idle = 0;
        recv_idle = 0;
        for (int n = 0; n < 150; n++)
            send_req(rand_req(), 1'b0, z);

        send_req(mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd25600), 1'b0, z);
        send_req(mk_req(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'($urandom)), 1'b0, z);
        send_req(mk_req(OP_ADD_SCORE, $urandom, 32'd0, 32'd9, 16'd0), 1'b0, z);
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
